// ----- hw/rtl/fbpa_pkg.sv -----
`default_nettype none

package fbpa_pkg;

  // Request kinds carried in in_tuser
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_DONE       = 3'd0,
    ST_ALL_FREE   = 3'd1,
    ST_LEFT_FULL  = 3'd2,
    ST_REJECTED   = 3'd3,
    ST_ALLOC_FAIL = 3'd4
  } status_t;

  // Field widths fixed by the interface
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned ENTRY_W  = 9;
  localparam int unsigned STATUS_W = 3;

endpackage : fbpa_pkg

`default_nettype wire

// ----- hw/rtl/fixed_block_pool_allocator_top.sv -----
`default_nettype none

// Fixed-size slot pool allocator. Each input item is an allocate (in_tuser = 0) or a free
// (in_tuser = 1, slot in in_tdata) and yields exactly one result item. Allocates pop the
// head of a linked free list kept in a RAM of CAPACITY links, falling back to a bump
// counter for never-used slots; frees push onto that list. S_IDLE latches each request
// while the RAM reads the link of the current list head; S_EXEC decides and writes back,
// holding while the output register is full and not taken. A finished result
// waits in the output register while the next item is taken. The link RAM needs no
// clearing after reset, so items are accepted straight away. pool_entries (cfg port,
// reset 256, values above CAPACITY act as CAPACITY) should only be written while idle.
module fixed_block_pool_allocator_top #(
  parameter int unsigned CAPACITY = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] slot_index
  input  wire logic [0:0]  in_tuser,   // [0] action
  // result items
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [15:0] out_tdata,  // [7:0] granted_index, [10:8] status, rest zero
  output      logic [0:0]  out_tuser,  // [0] granted
  // configuration
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [8:0]  cfg_data    // pool_entries
);

  import fbpa_pkg::*;

  localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LINK_W = $clog2(CAPACITY + 1);
  localparam int unsigned CNT_W  = (LINK_W > ENTRY_W) ? LINK_W : ENTRY_W;
  localparam logic [CNT_W-1:0]  CAP_C  = CNT_W'(CAPACITY);
  localparam logic [LINK_W-1:0] CAP_L  = LINK_W'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t              state_r;
  logic                act_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [ENTRY_W-1:0]  pool_entries_r;
  logic [LINK_W-1:0]   free_head_r, free_head_nxt;
  logic [LINK_W-1:0]   bump_r, bump_nxt;
  logic [LINK_W-1:0]   in_use_r, in_use_nxt;
  logic                out_valid_r;
  logic                out_granted_r, out_granted_nxt;
  logic [SLOT_W-1:0]   out_index_r, out_index_nxt;
  status_t             out_status_r, out_status_nxt;

  logic                in_fire;
  logic                exec_done;
  logic                ram_wr_en;
  logic [IDX_W-1:0]    ram_wr_addr;
  logic [LINK_W-1:0]   ram_wr_data;
  logic [LINK_W-1:0]   head_link;

  logic [CNT_W-1:0]    eff;
  logic [CNT_W-1:0]    use_w, head_w, bump_w, slot_w, given_w;

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_status_r, out_index_r};
  assign out_tuser  = out_granted_r;

  // result slot free this cycle
  assign exec_done = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // link RAM; read port always follows the list head
  fbpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (CAPACITY)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (free_head_r[IDX_W-1:0]),
    .rd_data (head_link)
  );

  // widened views for comparison against the effective pool size
  always_comb begin
    eff    = (CNT_W'(pool_entries_r) > CAP_C) ? CAP_C : CNT_W'(pool_entries_r);
    use_w  = CNT_W'(in_use_r);
    head_w = CNT_W'(free_head_r);
    bump_w = CNT_W'(bump_r);
    slot_w = CNT_W'(slot_r);
  end

  // decide the request
  always_comb begin
    free_head_nxt   = free_head_r;
    bump_nxt        = bump_r;
    in_use_nxt      = in_use_r;
    out_granted_nxt = 1'b0;
    out_status_nxt  = ST_DONE;
    given_w         = '0;
    ram_wr_en       = 1'b0;
    ram_wr_addr     = slot_w[IDX_W-1:0];
    ram_wr_data     = free_head_r;
    if (act_r == ACT_ALLOC) begin
      priority if (use_w >= eff) begin
        out_status_nxt = ST_ALLOC_FAIL;
      end else if (head_w < CAP_C) begin
        given_w         = head_w;
        free_head_nxt   = head_link;
        in_use_nxt      = LINK_W'(in_use_r + 1'b1);
        out_granted_nxt = 1'b1;
      end else if (bump_w < eff) begin
        given_w         = bump_w;
        bump_nxt        = LINK_W'(bump_r + 1'b1);
        in_use_nxt      = LINK_W'(in_use_r + 1'b1);
        out_granted_nxt = 1'b1;
      end else begin
        out_status_nxt = ST_ALLOC_FAIL;
      end
    end else begin
      if ((slot_w >= eff) || (in_use_r == '0)) begin
        out_status_nxt = ST_REJECTED;
      end else begin
        ram_wr_en     = exec_done;
        free_head_nxt = slot_w[LINK_W-1:0];
        in_use_nxt    = LINK_W'(in_use_r - 1'b1);
        priority if (in_use_r == LINK_W'(1)) begin
          out_status_nxt = ST_ALL_FREE;
        end else if (use_w == eff) begin
          out_status_nxt = ST_LEFT_FULL;
        end else begin
          out_status_nxt = ST_DONE;
        end
      end
    end
    out_index_nxt = given_w[SLOT_W-1:0];
  end

  // sequencer, pool state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      pool_entries_r <= ENTRY_W'(256);
      free_head_r    <= CAP_L;
      bump_r         <= '0;
      in_use_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pool_entries_r <= cfg_data;
      end
      // a new result replaces the one leaving in the same cycle
      if (exec_done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec_done) begin
            free_head_r <= free_head_nxt;
            bump_r      <= bump_nxt;
            in_use_r    <= in_use_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // item payload and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_tuser[0];
      slot_r <= in_tdata;
    end
    if (exec_done) begin
      out_granted_r <= out_granted_nxt;
      out_index_r   <= out_index_nxt;
      out_status_r  <= out_status_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fire_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execution");

  a_grant_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_granted_r) |-> (out_status_r == ST_DONE))
    else $error("granted result with non-done status");

  a_grant_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_done && out_granted_nxt) |=> (in_use_r == LINK_W'($past(in_use_r) + 1'b1)))
    else $error("grant did not bump the in-use count");

  a_bump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (bump_r <= CAP_L) && (in_use_r <= CAP_L))
    else $error("bump pointer or in-use count beyond capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (exec_done && (act_r == ACT_FREE)))
    else $error("link RAM written outside a free");
`endif

endmodule : fixed_block_pool_allocator_top

`default_nettype wire

// ----- hw/rtl/fbpa_ram.sv -----
`default_nettype none

// Single-port-write, single-port-read RAM with registered read data
module fbpa_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule : fbpa_ram

`default_nettype wire

// ----- tb/fixed_block_pool_allocator_top_tb.sv -----
module fixed_block_pool_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  localparam int POOL_CAP = 256;

  // One queued request; from_held means the slot is chosen from the granted slots (at random
  // if none are held) when the item is put on the bus
  typedef struct packed {
    logic       act;
    logic [7:0] slot;
    logic       from_held;
  } pool_req_t;

  typedef struct packed {
    logic       granted;
    logic [7:0] index;
    status_t    status;
  } pool_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] slot_index
  logic [0:0]  in_tuser = '0;    // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [7:0] granted_index, [10:8] status, rest zero
  logic [0:0]  out_tuser;        // [0] granted
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;    // pool_entries

  // Shadow of the allocator state
  logic [8:0]   chain_mem [POOL_CAP];
  logic [8:0]   list_head;
  logic [8:0]   bump_ptr;
  logic [8:0]   used_count;
  logic [8:0]   pool_size;

  pool_req_t    pending_reqs [$];
  pool_result_t awaited_results [$];
  logic [7:0]   held_slots [$];

  int fail_count = 0;
  int item_total = 0;
  int idle_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  bit big_fill_done = 0;

  fixed_block_pool_allocator_top #(
    .CAPACITY (POOL_CAP)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
    fail_count++;
  endtask

  // Work out the result of one accepted item and advance the shadow state
  task automatic predict_pool_step(input logic act, input logic [7:0] slot);
    pool_result_t res;
    int eff;
    bit found;
    eff = (pool_size > POOL_CAP) ? POOL_CAP : int'(pool_size);
    res.granted = 1'b0;
    res.index = '0;
    res.status = ST_DONE;
    found = 0;
    if (act == ACT_ALLOC) begin
      if (used_count >= eff) begin
        res.status = ST_ALLOC_FAIL;
      end else if (list_head < POOL_CAP) begin
        res.granted = 1'b1;
        res.index = list_head[7:0];
        list_head = chain_mem[list_head[7:0]];
        if (list_head > POOL_CAP) list_head = POOL_CAP;
        used_count++;
      end else if (bump_ptr < eff) begin
        res.granted = 1'b1;
        res.index = bump_ptr[7:0];
        bump_ptr++;
        used_count++;
      end else begin
        res.status = ST_ALLOC_FAIL;
      end
      if (res.granted) held_slots.push_back(res.index);
    end else if (slot >= eff || used_count == 0) begin
      res.status = ST_REJECTED;
    end else begin
      chain_mem[slot] = list_head;
      list_head = {1'b0, slot};
      used_count--;
      if (used_count == 0) res.status = ST_ALL_FREE;
      else if (used_count + 1 == eff) res.status = ST_LEFT_FULL;
      // forget one holder of this slot, if any
      for (int k = 0; k < held_slots.size() && !found; k++) begin
        if (held_slots[k] == slot) begin
          held_slots.delete(k);
          found = 1;
        end
      end
    end
    awaited_results.push_back(res);
  endtask

  function automatic logic [7:0] pick_held_slot();
    if (held_slots.size() == 0) return 8'($urandom_range(0, 255));
    return held_slots[$urandom_range(0, held_slots.size() - 1)];
  endfunction

  // Request driver: predicts on acceptance, then presents the next item or idles
  always @(posedge clk) begin : drive_requests
    pool_req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) predict_pool_step(in_tuser[0], in_tdata);
      if (!in_tvalid || in_tready) begin
        if (idle_pct != 0 && in_gap != 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
          in_gap = $urandom_range(0, 18);
          in_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          if (nxt.from_held) nxt.slot = pick_held_slot();
          in_tvalid <= 1'b1;
          in_tuser <= nxt.act;
          in_tdata <= nxt.slot;
        end else begin
          in_gap = 0;
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk) begin : check_results
    pool_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("result with none awaited", 16'h0, out_tdata);
        end else begin
          want = awaited_results.pop_front();
          if (out_tuser[0] !== want.granted)
            flag_mismatch("granted", 16'(want.granted), 16'(out_tuser[0]));
          if (out_tdata[7:0] !== want.index)
            flag_mismatch("granted_index", 16'(want.index), 16'(out_tdata[7:0]));
          if (out_tdata[10:8] !== want.status)
            flag_mismatch("status", 16'(want.status), 16'(out_tdata[10:8]));
          if (out_tdata[15:11] !== '0)
            flag_mismatch("tdata padding", 16'h0, 16'(out_tdata[15:11]));
        end
      end
      if (idle_pct != 0 && out_gap != 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
        out_gap = $urandom_range(0, 18);
        out_tready <= 1'b0;
      end else begin
        out_gap = 0;
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_req(input logic act, input logic [7:0] slot, input logic from_held);
    pool_req_t r;
    r.act = act;
    r.slot = slot;
    r.from_held = from_held;
    pending_reqs.push_back(r);
    item_total++;
  endtask

  // Sender holds off until every item has come back
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_tvalid || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_pool_size(input logic [8:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    pool_size = value;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // One setting of the pool size, then runs of allocates and frees
  task automatic run_phase(input logic [8:0] size, input int pct, input int budget);
    int eff;
    int start;
    int run_cap;
    int len;
    int hi;
    set_pool_size(size);
    idle_pct = pct;
    eff = (size > POOL_CAP) ? POOL_CAP : int'(size);
    run_cap = (eff < 24) ? eff : 24;
    hi = (eff + 3 > 255) ? 255 : eff + 3;
    start = item_total;
    // a full pool once: fill it, run past the end, then hand everything back
    if (eff >= 200 && !big_fill_done) begin
      big_fill_done = 1;
      repeat (eff + 2) push_req(ACT_ALLOC, 8'h00, 1'b0);
      repeat (eff + 2) push_req(ACT_FREE, 8'h00, 1'b1);
    end
    while (item_total - start < budget) begin
      len = $urandom_range(1, run_cap + 2);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          repeat (len) push_req(ACT_ALLOC, 8'($urandom_range(0, 255)), 1'b0);
        end
        3, 4, 5: begin
          repeat (len) push_req(ACT_FREE, 8'h00, 1'b1);
        end
        6: begin
          repeat ($urandom_range(4, 20)) begin
            if ($urandom_range(0, 1) != 0) push_req(ACT_ALLOC, 8'h00, 1'b0);
            else push_req(ACT_FREE, 8'h00, 1'b1);
          end
        end
        7: begin
          // noise: anything goes
          repeat ($urandom_range(1, 6))
            push_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0);
        end
        8: begin
          // frees anywhere up to just past the top of the range
          repeat ($urandom_range(1, 4))
            push_req(ACT_FREE, 8'($urandom_range(0, hi)), 1'b0);
        end
        default: begin
          if (eff <= 32) begin
            repeat (eff + 2) push_req(ACT_ALLOC, 8'h00, 1'b0);
            repeat (eff + 2) push_req(ACT_FREE, 8'h00, 1'b1);
          end else begin
            repeat (len) push_req(ACT_ALLOC, 8'h00, 1'b0);
          end
        end
      endcase
    end
    wait_drained();
  endtask

  initial begin : run_test
    logic [8:0] corner_sizes [8];
    int phase_no;
    int pct;
    logic [8:0] size;
    corner_sizes = '{9'd256, 9'd1, 9'd2, 9'd0, 9'd257, 9'd511, 9'd255, 9'd3};
    for (int k = 0; k < POOL_CAP; k++) chain_mem[k] = '0;
    list_head = POOL_CAP;
    bump_ptr = '0;
    used_count = '0;
    pool_size = 9'd256;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset size, free with nothing out, free of a never-issued slot, reuse
    idle_pct = 20;
    push_req(ACT_FREE, 8'd0, 1'b0);
    push_req(ACT_ALLOC, 8'hFF, 1'b0);
    push_req(ACT_FREE, 8'd255, 1'b0);
    push_req(ACT_ALLOC, 8'h00, 1'b0);
    push_req(ACT_FREE, 8'd255, 1'b0);
    wait_drained();

    // one slot: a list entry beyond the size, exhaustion, all free over left full
    set_pool_size(9'd1);
    push_req(ACT_ALLOC, 8'h00, 1'b0);
    push_req(ACT_ALLOC, 8'h00, 1'b0);
    push_req(ACT_FREE, 8'd0, 1'b0);
    push_req(ACT_ALLOC, 8'h00, 1'b0);
    push_req(ACT_ALLOC, 8'h00, 1'b0);
    push_req(ACT_FREE, 8'd0, 1'b0);
    wait_drained();

    // zero size: everything fails or is rejected
    set_pool_size(9'd0);
    push_req(ACT_ALLOC, 8'h00, 1'b0);
    push_req(ACT_FREE, 8'd0, 1'b0);
    wait_drained();

    // two slots: bump, full, left full, out of range
    set_pool_size(9'd2);
    push_req(ACT_ALLOC, 8'h00, 1'b0);
    push_req(ACT_ALLOC, 8'h00, 1'b0);
    push_req(ACT_ALLOC, 8'h00, 1'b0);
    push_req(ACT_FREE, 8'd1, 1'b0);
    push_req(ACT_FREE, 8'd255, 1'b0);
    push_req(ACT_FREE, 8'd0, 1'b0);
    wait_drained();

    // oversized setting acts as full capacity
    set_pool_size(9'd511);
    push_req(ACT_ALLOC, 8'h00, 1'b0);
    push_req(ACT_ALLOC, 8'h00, 1'b0);
    push_req(ACT_FREE, 8'hAA, 1'b0);
    push_req(ACT_FREE, 8'h55, 1'b0);
    wait_drained();

    // Random phases, corner sizes first, mostly small pools afterwards
    phase_no = 0;
    while (item_total < 1800) begin
      if (phase_no < 8) begin
        size = corner_sizes[phase_no];
      end else if ($urandom_range(0, 3) != 0) begin
        size = 9'($urandom_range(1, 16));
      end else begin
        size = 9'($urandom_range(0, 511));
      end
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 10;
        2: pct = 30;
        default: pct = 60;
      endcase
      run_phase(size, pct, $urandom_range(60, 140));
      phase_no++;
    end

    // closing stretch at full rate
    run_phase(9'($urandom_range(2, 12)), 0, 60);

    repeat (10) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
